### hw/rtl/vn3d_pkg.sv
// ----------------------------------------------------------------------------
// vn3d_pkg
// Shared widths and the front-to-back queue entry for vector_normalize_3d.
// ----------------------------------------------------------------------------
package vn3d_pkg;

	localparam int IN_W    = 24;  // input component width
	localparam int OUT_W   = 16;  // Q1.15 result width
	localparam int SQ_W    = 47;  // square of a 24-bit magnitude
	localparam int SUM_W   = 48;  // sum of three squares
	localparam int QUO_W   = 33;  // floor(2^32 * c^2 / sum), up to 2^32
	localparam int ROOT_W  = 17;  // isqrt of the quotient, up to 2^16
	localparam int LANES   = 3;
	localparam int FIFO_DEPTH = 4;

	localparam logic [OUT_W-1:0] POS_MAX = 16'h7fff;

	typedef struct packed {
		logic [LANES-1:0][SQ_W-1:0] sq;
		logic [SUM_W-1:0]           sum;
		logic [LANES-1:0]           neg;
	} entry_t;

endpackage

### hw/rtl/vn3d_fifo.sv
// ----------------------------------------------------------------------------
// vn3d_fifo
// Short register queue between the classify front and the divide/root back.
// ----------------------------------------------------------------------------
module vn3d_fifo #(
	parameter int DEPTH = vn3d_pkg::FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vn3d_pkg::entry_t push_data,
	output logic             full,
	input  logic             pop,
	output vn3d_pkg::entry_t pop_data,
	output logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	vn3d_pkg::entry_t mem_q [0:DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty)) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

### hw/rtl/vn3d_front.sv
// ----------------------------------------------------------------------------
// vn3d_front
// Accepts vectors: sign/magnitude split, squares, sum of squares.
// ----------------------------------------------------------------------------
module vn3d_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [vn3d_pkg::IN_W-1:0] vec_x,
	input  logic signed [vn3d_pkg::IN_W-1:0] vec_y,
	input  logic signed [vn3d_pkg::IN_W-1:0] vec_z,
	output logic                             push,
	output vn3d_pkg::entry_t                 push_data,
	input  logic                             full
);

	logic adv;
	logic v_s1, v_s2, v_s3;
	logic [vn3d_pkg::LANES-1:0][vn3d_pkg::IN_W-1:0] mag_s1;
	logic [vn3d_pkg::LANES-1:0]                     neg_s1, neg_s2, neg_s3;
	logic [vn3d_pkg::LANES-1:0][vn3d_pkg::SQ_W-1:0] sq_s2, sq_s3;
	logic [vn3d_pkg::SUM_W-1:0]                     sum_s3;
	logic [vn3d_pkg::LANES-1:0][vn3d_pkg::IN_W-1:0] raw;
	logic [vn3d_pkg::LANES-1:0][2*vn3d_pkg::IN_W-1:0] prod;

	assign adv      = !(v_s3 && full);
	assign in_stall = !adv;
	assign push     = v_s3 && !full;
	assign raw      = {vec_z, vec_y, vec_x};

	always_comb begin
		for (int l = 0; l < vn3d_pkg::LANES; l++)
			prod[l] = mag_s1[l] * mag_s1[l];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < vn3d_pkg::LANES; l++) begin
				neg_s1[l] <= raw[l][vn3d_pkg::IN_W-1];
				mag_s1[l] <= raw[l][vn3d_pkg::IN_W-1] ? (~raw[l] + 1'b1) : raw[l];
				sq_s2[l]  <= prod[l][vn3d_pkg::SQ_W-1:0];
			end
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			sq_s3  <= sq_s2;
			sum_s3 <= {1'b0, sq_s2[0]} + {1'b0, sq_s2[1]} + {1'b0, sq_s2[2]};
		end
	end

	assign push_data.sq  = sq_s3;
	assign push_data.sum = sum_s3;
	assign push_data.neg = neg_s3;

endmodule

### hw/rtl/vn3d_back.sv
// ----------------------------------------------------------------------------
// vn3d_back
// Pipelined restoring divide (c^2 * 2^32 / sum), pipelined integer square
// root, then round, sign and saturate into the output register.
// ----------------------------------------------------------------------------
module vn3d_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  vn3d_pkg::entry_t                  q_data,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [vn3d_pkg::OUT_W-1:0] unit_x,
	output logic signed [vn3d_pkg::OUT_W-1:0] unit_y,
	output logic signed [vn3d_pkg::OUT_W-1:0] unit_z,
	output logic                              zero_length
);

	localparam int QW = vn3d_pkg::QUO_W;
	localparam int RW = vn3d_pkg::ROOT_W;
	localparam int SW = vn3d_pkg::SUM_W;
	localparam int NL = vn3d_pkg::LANES;
	localparam int T2W = 2 * RW + 1;

	logic adv;
	logic out_valid_q;
	logic [NL-1:0][vn3d_pkg::OUT_W-1:0] unit_q;
	logic zero_q;

	// divider stage arrays, index 0 is the queue head
	logic [SW-1:0] d_rem [0:QW][0:NL-1];
	logic [QW-1:0] d_quo [0:QW][0:NL-1];
	logic [SW-1:0] d_sum [0:QW];
	logic [NL-1:0] d_neg [0:QW];
	logic          d_zero[0:QW];
	logic          d_vld [0:QW];

	// root stage arrays, index 0 is the divider output
	logic [QW-1:0]  r_quo [0:RW][0:NL-1];
	logic [RW-1:0]  r_s   [0:RW][0:NL-1];
	logic [2*RW-1:0] r_s2 [0:RW][0:NL-1];
	logic [NL-1:0]  r_neg [0:RW];
	logic           r_zero[0:RW];
	logic           r_vld [0:RW];

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && q_valid;

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			d_rem[0][l] = {1'b0, q_data.sq[l]};
			d_quo[0][l] = '0;
		end
		d_sum[0]  = q_data.sum;
		d_neg[0]  = q_data.neg;
		d_zero[0] = (q_data.sum == '0);
		d_vld[0]  = q_valid;
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				d_vld[j+1] <= 1'b0;
			else if (adv)
				d_vld[j+1] <= d_vld[j];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				d_sum[j+1]  <= d_sum[j];
				d_neg[j+1]  <= d_neg[j];
				d_zero[j+1] <= d_zero[j];
			end
		end
		for (genvar l = 0; l < NL; l++) begin : g_lane
			logic [SW:0] rr, diff;
			logic        ge;
			if (j == 0) begin : g_first
				// remainder starts at c^2 <= sum: top quotient bit without shift
				assign rr = {1'b0, d_rem[j][l]};
			end else begin : g_rest
				assign rr = {d_rem[j][l], 1'b0};
			end
			assign diff = rr - {1'b0, d_sum[j]};
			assign ge   = (rr >= {1'b0, d_sum[j]});
			always_ff @(posedge clk) begin
				if (adv) begin
					d_rem[j+1][l] <= ge ? diff[SW-1:0] : rr[SW-1:0];
					d_quo[j+1][l] <= {d_quo[j][l][QW-2:0], ge};
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			r_quo[0][l] = d_quo[QW][l];
			r_s[0][l]   = '0;
			r_s2[0][l]  = '0;
		end
		r_neg[0]  = d_neg[QW];
		r_zero[0] = d_zero[QW];
		r_vld[0]  = d_vld[QW];
	end

	for (genvar m = 0; m < RW; m++) begin : g_root
		localparam int B = RW - 1 - m;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				r_vld[m+1] <= 1'b0;
			else if (adv)
				r_vld[m+1] <= r_vld[m];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				r_neg[m+1]  <= r_neg[m];
				r_zero[m+1] <= r_zero[m];
			end
		end
		for (genvar l = 0; l < NL; l++) begin : g_lane
			logic [T2W-1:0] trial2;
			logic           ok;
			// (s + 2^B)^2 = s^2 + s*2^(B+1) + 2^(2B)
			assign trial2 = {1'b0, r_s2[m][l]}
				+ ({{(T2W-RW){1'b0}}, r_s[m][l]} << (B + 1))
				+ (T2W'(1) << (2 * B));
			assign ok = (trial2 <= {{(T2W-QW){1'b0}}, r_quo[m][l]});
			always_ff @(posedge clk) begin
				if (adv) begin
					r_quo[m+1][l] <= r_quo[m][l];
					r_s[m+1][l]   <= ok ? (r_s[m][l] | (RW'(1) << B)) : r_s[m][l];
					r_s2[m+1][l]  <= ok ? trial2[2*RW-1:0] : r_s2[m][l];
				end
			end
		end
	end

	// largest odd t <= s gives k = (t+1)/2 = (s+1)>>1
	logic [NL-1:0][RW-1:0] k;
	logic [NL-1:0][vn3d_pkg::OUT_W-1:0] res;
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			k[l] = RW'(({1'b0, r_s[RW][l]} + (RW+1)'(1)) >> 1);
			if (r_zero[RW])
				res[l] = '0;
			else if (r_neg[RW][l])
				res[l] = ~k[l][vn3d_pkg::OUT_W-1:0] + 1'b1;
			else if (k[l] > RW'(vn3d_pkg::POS_MAX))
				res[l] = vn3d_pkg::POS_MAX;
			else
				res[l] = k[l][vn3d_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= r_vld[RW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unit_q <= res;
			zero_q <= r_zero[RW];
		end
	end

	assign out_valid   = out_valid_q;
	assign unit_x      = unit_q[0];
	assign unit_y      = unit_q[1];
	assign unit_z      = unit_q[2];
	assign zero_length = zero_q;

	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && zero_q) |-> (unit_q == '0))
		else $error("zero vector with nonzero components");
	a_no_pop_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !pop)
		else $error("queue popped while back end held");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(unit_q) && $stable(zero_q)))
		else $error("result beat changed while stalled");

endmodule

### hw/rtl/vector_normalize_3d.sv
// ----------------------------------------------------------------------------
// vector_normalize_3d
// Signed 24-bit 3D vector to rounded, saturated Q1.15 unit vector.
// ----------------------------------------------------------------------------
// Takes one vector per cycle and returns one result per cycle in order while
// neither in_stall nor out_stall holds the flow. The front takes magnitudes,
// squares and the sum of squares in three stages and writes a short queue; the
// back pops it into a 33-stage restoring divider (c^2 * 2^32 / sum) and a
// 17-stage square root, then rounds into the output register. A zero vector
// returns zero components with zero_length set.
module vector_normalize_3d #(
	parameter int FIFO_DEPTH = vn3d_pkg::FIFO_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [vn3d_pkg::IN_W-1:0]  vec_x,
	input  logic signed [vn3d_pkg::IN_W-1:0]  vec_y,
	input  logic signed [vn3d_pkg::IN_W-1:0]  vec_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [vn3d_pkg::OUT_W-1:0] unit_x,
	output logic signed [vn3d_pkg::OUT_W-1:0] unit_y,
	output logic signed [vn3d_pkg::OUT_W-1:0] unit_z,
	output logic                              zero_length
);

	logic             push, full, pop, q_valid;
	vn3d_pkg::entry_t push_data, q_data;

	vn3d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	vn3d_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (q_data),
		.not_empty (q_valid)
	);

	vn3d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.unit_x      (unit_x),
		.unit_y      (unit_y),
		.unit_z      (unit_z),
		.zero_length (zero_length)
	);

endmodule

### tb/sv/vector_normalize_3d_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_normalize_3d_checker
// Watches both channels of vector_normalize_3d and compares every result beat
// against a bit-exact unit vector prediction made when the input beat is taken.
// ----------------------------------------------------------------------------
module vector_normalize_3d_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic signed [vn3d_pkg::IN_W-1:0]  vec_x,
	input  logic signed [vn3d_pkg::IN_W-1:0]  vec_y,
	input  logic signed [vn3d_pkg::IN_W-1:0]  vec_z,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [vn3d_pkg::OUT_W-1:0] unit_x,
	input  logic signed [vn3d_pkg::OUT_W-1:0] unit_y,
	input  logic signed [vn3d_pkg::OUT_W-1:0] unit_z,
	input  logic                              zero_length,
	output int                                errors,
	output int                                pending,
	output int                                results_seen,
	output int                                zero_seen
);

	typedef struct packed {
		logic [vn3d_pkg::OUT_W-1:0] ux;
		logic [vn3d_pkg::OUT_W-1:0] uy;
		logic [vn3d_pkg::OUT_W-1:0] uz;
		logic                       zl;
	} unit_vec_t;

	unit_vec_t expected_units[$];

	// Rounded magnitude of 32768*|c|/sqrt(sum): largest k with (2k-1)^2*sum <= 2^32*c2.
	function automatic logic [16:0] round_scale(logic [vn3d_pkg::SQ_W-1:0] c2,
			logic [vn3d_pkg::SUM_W-1:0] sum);
		logic [16:0]  lo;
		logic [16:0]  hi;
		logic [16:0]  mid;
		logic [33:0]  odd;
		logic [127:0] lhs;
		logic [127:0] rhs;
		lo = 0;
		hi = 17'd32768;
		rhs = {81'd0, c2} << 32;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			odd = 2 * mid - 1;
			lhs = 128'(odd) * 128'(odd) * 128'(sum);
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic unit_vec_t normalize(logic signed [vn3d_pkg::IN_W-1:0] cx,
			logic signed [vn3d_pkg::IN_W-1:0] cy, logic signed [vn3d_pkg::IN_W-1:0] cz);
		logic signed [vn3d_pkg::IN_W-1:0] comp[3];
		logic [vn3d_pkg::IN_W:0]    mag;
		logic [vn3d_pkg::SQ_W-1:0]  sq[3];
		logic [vn3d_pkg::SUM_W-1:0] sum;
		logic [16:0]                r;
		logic [vn3d_pkg::OUT_W-1:0] u[3];
		unit_vec_t                  res;
		comp[0] = cx;
		comp[1] = cy;
		comp[2] = cz;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			mag = comp[i][vn3d_pkg::IN_W-1] ? -{comp[i][vn3d_pkg::IN_W-1], comp[i]}
				: {1'b0, comp[i]};
			sq[i] = vn3d_pkg::SQ_W'(mag) * vn3d_pkg::SQ_W'(mag);
			sum += sq[i];
		end
		if (sum == 0) begin
			res = '{ux: '0, uy: '0, uz: '0, zl: 1'b1};
			return res;
		end
		for (int i = 0; i < 3; i++) begin
			r = round_scale(sq[i], sum);
			if (comp[i][vn3d_pkg::IN_W-1])
				u[i] = vn3d_pkg::OUT_W'(-r);
			else
				u[i] = (r > 17'd32767) ? vn3d_pkg::POS_MAX : vn3d_pkg::OUT_W'(r);
		end
		res = '{ux: u[0], uy: u[1], uz: u[2], zl: 1'b0};
		return res;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch @%0t result %0d: %s got %0d expected %0d",
			$realtime, results_seen, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		results_seen = 0;
		zero_seen = 0;
	end

	assign pending = expected_units.size();

	always @(posedge clk) begin
		unit_vec_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_units.push_back(normalize(vec_x, vec_y, vec_z));
			if (out_valid && !out_stall) begin
				if (expected_units.size() == 0) begin
					report("unexpected beat", 1, 0);
				end else begin
					want = expected_units.pop_front();
					if (unit_x !== want.ux) report("unit_x", unit_x, $signed(want.ux));
					if (unit_y !== want.uy) report("unit_y", unit_y, $signed(want.uy));
					if (unit_z !== want.uz) report("unit_z", unit_z, $signed(want.uz));
					if (zero_length !== want.zl) report("zero_length", zero_length, want.zl);
				end
				results_seen++;
				if (zero_length) zero_seen++;
			end
		end
	end

endmodule

### tb/sv/vector_normalize_3d_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_normalize_3d_tb
// Directed and random vectors through vector_normalize_3d with random gaps,
// random output stalls and a long output hold-off to fill the pipeline.
// ----------------------------------------------------------------------------
module vector_normalize_3d_tb;

	localparam int RANDOM_VECS = 1330;
	localparam int DRAIN_CYCLES = 200;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [vn3d_pkg::IN_W-1:0] vec_x;
	logic signed [vn3d_pkg::IN_W-1:0] vec_y;
	logic signed [vn3d_pkg::IN_W-1:0] vec_z;
	logic out_valid;
	logic out_stall;
	logic signed [vn3d_pkg::OUT_W-1:0] unit_x;
	logic signed [vn3d_pkg::OUT_W-1:0] unit_y;
	logic signed [vn3d_pkg::OUT_W-1:0] unit_z;
	logic zero_length;
	int   errors;
	int   pending;
	int   results_seen;
	int   zero_seen;
	int   vecs_sent;
	bit   calm;       // no idling on either side
	bit   hold_off;   // receiver holds off for a long stretch

	vector_normalize_3d dut (.*);

	vector_normalize_3d_checker chk (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: random stalls, a calm stretch and one long hold-off.
	initial begin
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off)
				out_stall <= 1'b1;
			else if (calm)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(99) < 30);
		end
	end

	initial begin
		hold_off = 1'b0;
		@(posedge arst_n);
		wait (vecs_sent >= 300);
		hold_off = 1'b1;
		repeat (150) @(posedge clk);
		hold_off = 1'b0;
	end

	task automatic send_vec(logic signed [vn3d_pkg::IN_W-1:0] x,
			logic signed [vn3d_pkg::IN_W-1:0] y, logic signed [vn3d_pkg::IN_W-1:0] z);
		while (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		vecs_sent++;
	endtask

	function automatic logic signed [vn3d_pkg::IN_W-1:0] rand_comp(int shape);
		logic signed [vn3d_pkg::IN_W-1:0] v;
		v = vn3d_pkg::IN_W'($urandom);
		case (shape)
			0: v = v >>> $urandom_range(23);
			1: v = $urandom_range(1) ? 24'sh7fffff - vn3d_pkg::IN_W'($urandom_range(3))
				: 24'sh800000 + vn3d_pkg::IN_W'($urandom_range(3));
			2: v = '0;
			3: v = vn3d_pkg::IN_W'($signed($urandom_range(6)) - 3);
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		int s;
		in_valid = 1'b0;
		vec_x = '0;
		vec_y = '0;
		vec_z = '0;
		calm = 1'b0;
		vecs_sent = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero vector, axes at both extremes, exact +1 saturation, ties
		send_vec(0, 0, 0);
		send_vec(1, 0, 0);
		send_vec(-1, 0, 0);
		send_vec(0, 24'sh7fffff, 0);
		send_vec(0, 0, 24'sh800000);
		send_vec(24'sh800000, 0, 0);
		send_vec(0, -5, 0);
		send_vec(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
		send_vec(24'sh800000, 24'sh800000, 24'sh800000);
		send_vec(24'sh800000, 24'sh7fffff, 24'sh800000);
		send_vec(3, 4, 0);
		send_vec(-3, 0, 4);
		send_vec(2, 3, 6);
		send_vec(1, 1, 1);
		send_vec(-1, -1, -1);
		send_vec(1, 2, 2);
		send_vec(24'sh555555, 24'shaaaaaa, 24'sh000001);
		send_vec(24'sh7fffff, 1, 0);
		send_vec(24'sh800000, 0, -1);
		send_vec(0, 0, 0);

		for (int n = 0; n < RANDOM_VECS; n++) begin
			calm = (n >= 700 && n < 900);
			s = $urandom_range(5);
			send_vec(rand_comp(s > 3 ? $urandom_range(4) : s),
				rand_comp($urandom_range(4)), rand_comp($urandom_range(4)));
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d vectors (%0d zero-length) incl. extremes, saturation and stalls.",
			results_seen, zero_seen);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
